// ----- design/sdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared widths, register indexes and character codes for the signed
// decimal formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_WIDTH  = 63;

	// decimal digits of the largest magnitude, 2**(VALUE_BITS-1)
	localparam int DIGITS      = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
	localparam int DIGIT_IDX_W = $clog2(DIGITS);
	localparam int DCOUNT_W    = $clog2(DIGITS + 1);
	localparam int BCD_W       = 4 * DIGITS;
	localparam int CONV_CNT_W  = $clog2(VALUE_BITS);

	localparam int FIELD_W = 6;
	localparam int INDEX_W = 3;
	localparam int WDATA_W = 6;

	typedef logic [FIELD_W-1:0] count_t;
	typedef logic [7:0]         char_t;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_FIELD_WIDTH     = 3'd0;
	localparam logic [INDEX_W-1:0] REG_PRECISION       = 3'd1;
	localparam logic [INDEX_W-1:0] REG_PRECISION_GIVEN = 3'd2;
	localparam logic [INDEX_W-1:0] REG_LEFT_ALIGN      = 3'd3;
	localparam logic [INDEX_W-1:0] REG_ZERO_PAD        = 3'd4;
	localparam logic [INDEX_W-1:0] REG_SIGN_MODE       = 3'd5;

	// sign modes for non-negative values
	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_PLUS  = 2'd1;
	localparam logic [1:0] SIGN_SPACE = 2'd2;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_ZERO  = 8'h30;

	localparam count_t PREC_MAX = count_t'(MAX_WIDTH - 1);

endpackage

// ----- design/signed_decimal_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_formatter
// Formats one signed value as printf-style decimal text, one ASCII
// character per output transfer.
// ----------------------------------------------------------------------------
// One value is taken at a time. After the input transfer, a shift-and-add-3
// binary to BCD converter runs one bit per cycle, the setup states ST_PREP1,
// ST_PREP2 and ST_PREP3 size the padding, sign and zero runs, then one
// character leaves the output register per cycle while the receiver takes
// them. The text is at most 63 characters, and an empty text gives one
// empty-marked result. The next value is accepted once the final character
// is in the output register, while it still waits to be taken.
// Configuration writes belong to idle periods only.
module signed_decimal_formatter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sdf_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [sdf_pkg::WDATA_W-1:0]   cfg_wdata,
	input  logic                          value_valid,
	output logic                          value_ready,
	input  logic [sdf_pkg::VALUE_BITS-1:0] value,
	output logic                          char_valid,
	input  logic                          char_ready,
	output logic [7:0]                    out_char,
	output logic                          last,
	output logic                          empty_res
);
	import sdf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_PREP1 = 3'd2;
	localparam logic [2:0] ST_PREP2 = 3'd3;
	localparam logic [2:0] ST_PREP3 = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	// configuration
	count_t     field_width_q;
	count_t     precision_q;
	logic       precision_given_q;
	logic       left_align_q;
	logic       zero_pad_q;
	logic [1:0] sign_mode_q;

	logic [2:0]              state_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [CONV_CNT_W-1:0]   conv_cnt_q;
	logic                    neg_q;
	logic                    raw_zero_q;

	logic [DCOUNT_W-1:0]     digit_count_q;
	count_t                  shown_q;
	count_t                  lead_zero_q;
	char_t                   sign_char_q;
	logic                    has_sign_q;
	logic                    zeros_fill_q;
	count_t                  pad_q;

	// run boundaries, as character positions
	count_t                  lead_sp_end_q;
	count_t                  sign_end_q;
	count_t                  zero_end_q;
	count_t                  dig_end_q;
	count_t                  total_q;
	count_t                  pos_q;

	logic                    char_valid_q;
	char_t                   char_q;
	logic                    last_q;
	logic                    empty_q;

	// conversion step: add 3 to every digit of 5 or more, then shift in one bit
	logic [BCD_W-1:0]        bcd_adj;
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// significant digit count, at least one
	logic [DCOUNT_W-1:0]     dcount;
	always_comb begin
		dcount = DCOUNT_W'(1);
		for (int i = 1; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0)
				dcount = DCOUNT_W'(i + 1);
		end
	end

	count_t prec_sat;
	count_t dcount_ext;
	count_t shown_n;
	count_t len_n;
	assign prec_sat   = (precision_q > PREC_MAX) ? PREC_MAX : precision_q;
	assign dcount_ext = count_t'(dcount);
	always_comb begin
		if (precision_given_q && prec_sat == '0 && raw_zero_q)
			shown_n = '0;
		else if (precision_given_q && prec_sat > dcount_ext)
			shown_n = prec_sat;
		else
			shown_n = dcount_ext;
	end
	assign len_n = shown_q + count_t'(has_sign_q);

	// character at the current position
	count_t                  dig_off;
	logic [DIGIT_IDX_W-1:0]  dig_idx;
	char_t                   char_n;
	logic                    emit_load;
	logic                    at_last;
	assign dig_off   = dig_end_q - count_t'(1) - pos_q;
	assign dig_idx   = dig_off[DIGIT_IDX_W-1:0];
	assign emit_load = (state_q == ST_EMIT) && (!char_valid_q || char_ready);
	assign at_last   = (pos_q == total_q - count_t'(1));
	always_comb begin
		if (pos_q < lead_sp_end_q)
			char_n = CH_SPACE;
		else if (pos_q < sign_end_q)
			char_n = sign_char_q;
		else if (pos_q < zero_end_q)
			char_n = CH_ZERO;
		else if (pos_q < dig_end_q)
			char_n = CH_ZERO + char_t'(bcd_q[{dig_idx, 2'b00} +: 4]);
		else
			char_n = CH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q     <= '0;
			precision_q       <= '0;
			precision_given_q <= 1'b0;
			left_align_q      <= 1'b0;
			zero_pad_q        <= 1'b0;
			sign_mode_q       <= SIGN_NONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIELD_WIDTH:     field_width_q     <= cfg_wdata;
				REG_PRECISION:       precision_q       <= cfg_wdata;
				REG_PRECISION_GIVEN: precision_given_q <= cfg_wdata[0];
				REG_LEFT_ALIGN:      left_align_q      <= cfg_wdata[0];
				REG_ZERO_PAD:        zero_pad_q        <= cfg_wdata[0];
				REG_SIGN_MODE:       sign_mode_q       <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			conv_cnt_q   <= '0;
			pos_q        <= '0;
			char_valid_q <= 1'b0;
		end else begin
			// a load refills the output register in the cycle it drains
			if (emit_load)
				char_valid_q <= 1'b1;
			else if (char_ready)
				char_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (value_valid) begin
						conv_cnt_q <= '0;
						state_q    <= ST_CONV;
					end
				end
				ST_CONV: begin
					conv_cnt_q <= conv_cnt_q + CONV_CNT_W'(1);
					if (conv_cnt_q == CONV_CNT_W'(VALUE_BITS - 1))
						state_q <= ST_PREP1;
				end
				ST_PREP1: state_q <= ST_PREP2;
				ST_PREP2: state_q <= ST_PREP3;
				ST_PREP3: begin
					pos_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						pos_q <= pos_q + count_t'(1);
						if (total_q == '0 || at_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && value_valid) begin
			neg_q      <= value[VALUE_BITS-1];
			raw_zero_q <= (value == '0);
			mag_q      <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
			bcd_q      <= '0;
		end
		if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
		if (state_q == ST_PREP1) begin
			digit_count_q <= dcount;
			shown_q       <= shown_n;
			lead_zero_q   <= (shown_n > dcount_ext) ? shown_n - dcount_ext : '0;
			zeros_fill_q  <= zero_pad_q && !left_align_q && !precision_given_q;
			if (neg_q) begin
				sign_char_q <= CH_MINUS;
				has_sign_q  <= 1'b1;
			end else if (sign_mode_q == SIGN_PLUS) begin
				sign_char_q <= CH_PLUS;
				has_sign_q  <= 1'b1;
			end else if (sign_mode_q == SIGN_SPACE) begin
				sign_char_q <= CH_SPACE;
				has_sign_q  <= 1'b1;
			end else begin
				sign_char_q <= CH_NUL;
				has_sign_q  <= 1'b0;
			end
		end
		if (state_q == ST_PREP2) begin
			pad_q <= (field_width_q > len_n) ? field_width_q - len_n : '0;
			// no digits at all when the shown count is zero
			if (shown_q == '0)
				digit_count_q <= '0;
		end
		if (state_q == ST_PREP3) begin
			lead_sp_end_q <= (!left_align_q && !zeros_fill_q) ? pad_q : '0;
			sign_end_q    <= ((!left_align_q && !zeros_fill_q) ? pad_q : '0)
			                 + count_t'(has_sign_q);
			zero_end_q    <= ((!left_align_q) ? pad_q : '0) + count_t'(has_sign_q)
			                 + lead_zero_q;
			dig_end_q     <= ((!left_align_q) ? pad_q : '0) + count_t'(has_sign_q)
			                 + lead_zero_q + count_t'(digit_count_q);
			total_q       <= pad_q + count_t'(has_sign_q) + lead_zero_q
			                 + count_t'(digit_count_q);
		end
		if (emit_load) begin
			if (total_q == '0) begin
				char_q  <= CH_NUL;
				last_q  <= 1'b1;
				empty_q <= 1'b1;
			end else begin
				char_q  <= char_n;
				last_q  <= at_last;
				empty_q <= 1'b0;
			end
		end
	end

	assign value_ready = (state_q == ST_IDLE);
	assign char_valid  = char_valid_q;
	assign out_char    = char_q;
	assign last        = last_q;
	assign empty_res   = empty_q;

	// an empty result carries no character and ends the text
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && empty_res |-> last && out_char == CH_NUL)
		else $error("empty result without last or with a character");

	// busy at the start of the conversion after a value transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_ready |=> !value_ready ##1 !value_ready)
		else $error("value taken while still converting");

	// digit reads stay inside the converted digits
	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && pos_q >= zero_end_q && pos_q < dig_end_q
		|-> dig_off < count_t'(digit_count_q))
		else $error("digit read outside the significant digits");

	// emission never runs past the text length
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && total_q != '0 |-> pos_q < total_q)
		else $error("character position beyond text length");

endmodule
